FILE: hw/rtl/hrs_pkg.sv
// ----------------------------------------------------------------------------
// hrs_pkg
// Shared types, constants and helpers of the response header scanner.
// ----------------------------------------------------------------------------
package hrs_pkg;

   localparam int DATE_BYTES  = 32;
   localparam int LENGTH_BITS = 48;
   localparam int DAW         = $clog2(DATE_BYTES);
   localparam int DLW         = 6;
   localparam int QDEPTH      = 4;
   localparam int QPW         = $clog2(QDEPTH);

   localparam logic [8*4-1:0]  PROTO_TAG = "HTTP";
   localparam logic [8*14-1:0] CL_TEXT  = "content-length";
   localparam logic [8*13-1:0] LM_TEXT  = "last-modified";
   localparam logic [3:0]      CL_LEN   = 4'd14;
   localparam logic [3:0]      LM_LEN   = 4'd13;
   localparam logic [7:0]      CH_LF    = 8'd10;
   localparam logic [7:0]      CH_COLON = 8'h3a;
   localparam logic [7:0]      CH_PLUS  = 8'h2b;
   localparam logic [2:0]      CODE_DIGITS = 3'd3;
   localparam logic [2:0]      BAD_TOKEN   = 3'd7;

   typedef enum logic [3:0] {
      PH_HEAD, PH_NAME_LEAD, PH_NAME_BODY, PH_NAME_TAIL, PH_VAL_LEAD,
      PH_VAL_BODY, PH_TOK1, PH_GAP, PH_TOK2, PH_REST
   } phase_type;

   typedef enum logic {
      BK_IDLE, BK_DRAIN
   } back_state_type;

   typedef enum logic {
      KIND_SUMMARY = 1'b0,
      KIND_DATE    = 1'b1
   } kind_type;

   typedef struct packed {
      logic                   wr_en;
      logic [DAW:0]           wr_addr;
      logic [7:0]             wr_data;
      logic                   sum_en;
      logic [9:0]             resp_code;
      logic                   status_found;
      logic [LENGTH_BITS-1:0] body_length;
      logic [DLW-1:0]         date_length;
      logic                   date_truncated;
      logic                   bank;
   } qent_type;

   function automatic logic is_ws(logic [7:0] c);
      return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39);
   endfunction

   function automatic logic [7:0] to_lower(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
   endfunction

   function automatic logic [7:0] cl_char(logic [3:0] i);
      return (i < CL_LEN) ? CL_TEXT[8*(13 - 32'(i)) +: 8] : 8'd0;
   endfunction

   function automatic logic [7:0] lm_char(logic [3:0] i);
      return (i < LM_LEN) ? LM_TEXT[8*(12 - 32'(i)) +: 8] : 8'd0;
   endfunction

endpackage

FILE: hw/rtl/hrs_if.sv
// ----------------------------------------------------------------------------
// hrs_req_if / hrs_rsp_if
// Valid/ready channels of the response header scanner.
// ----------------------------------------------------------------------------
interface hrs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_block;
   modport source (output valid, data_byte, end_of_block, input ready);
   modport sink (input valid, data_byte, end_of_block, output ready);
endinterface

interface hrs_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [9:0]  resp_code;
   logic        status_found;
   logic [47:0] body_length;
   logic [5:0]  date_length;
   logic        date_truncated;
   logic [7:0]  date_byte;
   logic        last;
   modport source (output valid, kind, resp_code, status_found, body_length,
                   date_length, date_truncated, date_byte, last, input ready);
   modport sink (input valid, kind, resp_code, status_found, body_length,
                 date_length, date_truncated, date_byte, last, output ready);
endinterface

FILE: hw/rtl/hrs_front.sv
// ----------------------------------------------------------------------------
// hrs_front
// Scans one header byte per cycle while the queue has room; issues date writes and block summaries.
// ----------------------------------------------------------------------------
module hrs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_eob,
   output logic              in_ready,
   input  logic              q_full,
   output logic              q_push,
   output hrs_pkg::qent_type q_data
);
   import hrs_pkg::*;

   localparam int LB = LENGTH_BITS;

   phase_type      ph_ff, ph_in;
   logic [2:0]     pmc_ff, pmc_in;
   logic [1:0]     nmf_ff, nmf_in;
   logic [3:0]     nci_ff, nci_in;
   logic [2:0]     tdc_ff, tdc_in;
   logic [9:0]     tdig_ff, tdig_in;
   logic [LB-1:0]  acc_ff, acc_in;
   logic           nf_dig_ff, nf_dig_in;
   logic           nf_over_ff, nf_over_in;
   logic           nf_stop_ff, nf_stop_in;
   logic [9:0]     sc_ff, sc_in;
   logic           sf_ff, sf_in;
   logic [LB-1:0]  cl_ff, cl_in;
   logic           bsel_ff, bsel_in;
   logic [DLW-1:0] wlen_ff, wlen_in;
   logic [DLW-1:0] wtl_ff, wtl_in;
   logic [DLW-1:0] clen_ff, clen_in;
   logic           ctr_ff, ctr_in;

   logic           accept;
   logic [7:0]     c;
   logic [7:0]     lc;
   logic [LB+3:0]  prod;
   qent_type       ent;

   assign in_ready = !q_full;
   assign accept   = in_valid && in_ready;
   assign c        = in_byte;
   assign lc       = to_lower(in_byte);
   assign prod     = ({4'd0, acc_ff} << 3) + ({4'd0, acc_ff} << 1)
                     + (LB+4)'(c - 8'h30);

   always_comb begin
      ph_in = ph_ff; pmc_in = pmc_ff; nmf_in = nmf_ff; nci_in = nci_ff;
      tdc_in = tdc_ff; tdig_in = tdig_ff; acc_in = acc_ff;
      nf_dig_in = nf_dig_ff; nf_over_in = nf_over_ff; nf_stop_in = nf_stop_ff;
      sc_in = sc_ff; sf_in = sf_ff; cl_in = cl_ff; bsel_in = bsel_ff;
      wlen_in = wlen_ff; wtl_in = wtl_ff; clen_in = clen_ff; ctr_in = ctr_ff;
      ent = '0;

      if (c != CH_LF) begin
         if (ph_in == PH_HEAD) begin
            if (c == PROTO_TAG[8*(3 - 32'(pmc_ff[1:0])) +: 8]) begin
               pmc_in = pmc_ff + 3'd1;
               if (pmc_in == 3'd4) begin
                  ph_in = PH_TOK1;
               end
            end else if (pmc_ff == 3'd0) begin
               ph_in = PH_NAME_LEAD;
            end else begin
               ph_in  = PH_NAME_BODY;
               nmf_in = 2'b00;
               nci_in = {1'b0, pmc_ff};
            end
         end
         if (ph_in == PH_TOK1 && ph_ff == PH_HEAD) begin
         end else if (ph_in inside {PH_NAME_LEAD, PH_NAME_BODY, PH_NAME_TAIL}) begin
            if (c == CH_COLON) begin
               if (ph_in == PH_NAME_LEAD) begin
                  nmf_in = 2'b00;
               end else begin
                  if (nci_in != CL_LEN) nmf_in[0] = 1'b0;
                  if (nci_in != LM_LEN) nmf_in[1] = 1'b0;
               end
               ph_in = PH_VAL_LEAD;
               acc_in = '0; nf_dig_in = 1'b0; nf_over_in = 1'b0; nf_stop_in = 1'b0;
               wlen_in = '0; wtl_in = '0;
            end else if (is_ws(c)) begin
               if (ph_in == PH_NAME_BODY) ph_in = PH_NAME_TAIL;
            end else begin
               if (ph_in == PH_NAME_TAIL) nmf_in = 2'b00;
               ph_in = PH_NAME_BODY;
               if (nci_in >= CL_LEN || lc != cl_char(nci_in)) nmf_in[0] = 1'b0;
               if (nci_in >= LM_LEN || lc != lm_char(nci_in)) nmf_in[1] = 1'b0;
               if (nci_in != 4'd15) nci_in = nci_in + 4'd1;
            end
         end else if (ph_in inside {PH_VAL_LEAD, PH_VAL_BODY}) begin
            if (!(ph_in == PH_VAL_LEAD && is_ws(c))) begin
               if (nmf_in[0] && !nf_stop_ff) begin
                  if (is_digit(c)) begin
                     nf_dig_in = 1'b1;
                     if (!nf_over_ff) begin
                        if (prod[LB+3:LB] != 4'd0) nf_over_in = 1'b1;
                        else acc_in = prod[LB-1:0];
                     end
                  end else if (!(ph_in == PH_VAL_LEAD && c == CH_PLUS)) begin
                     nf_stop_in = 1'b1;
                  end
               end
               if (nmf_in[1]) begin
                  if (32'(wlen_ff) < DATE_BYTES) begin
                     ent.wr_en   = 1'b1;
                     ent.wr_addr = {!bsel_ff, wlen_ff[DAW-1:0]};
                     ent.wr_data = c;
                     wlen_in     = wlen_ff + DLW'(1);
                     if (!is_ws(c)) wtl_in = wlen_in;
                  end else if (!is_ws(c)) begin
                     nf_over_in = 1'b1;
                  end
               end
               ph_in = PH_VAL_BODY;
            end
         end else if (ph_in == PH_TOK1) begin
            if (is_ws(c)) ph_in = PH_GAP;
         end else if (ph_in inside {PH_GAP, PH_TOK2}) begin
            if (ph_in == PH_GAP && !is_ws(c)) ph_in = PH_TOK2;
            if (ph_in == PH_TOK2) begin
               if (is_ws(c)) begin
                  ph_in = PH_REST;
               end else if (is_digit(c) && tdc_in < CODE_DIGITS) begin
                  tdig_in = 10'((tdig_in << 3) + (tdig_in << 1) + 10'(c - 8'h30));
                  tdc_in  = tdc_in + 3'd1;
               end else begin
                  tdc_in = BAD_TOKEN;
               end
            end
         end
      end

      if (c == CH_LF || in_eob) begin
         if ((ph_in == PH_TOK2 || ph_in == PH_REST) && tdc_in == CODE_DIGITS) begin
            sc_in = tdig_in;
            sf_in = 1'b1;
         end
         if (ph_in == PH_VAL_BODY) begin
            if (nmf_in[0] && nf_dig_in && !nf_over_in) cl_in = acc_in;
            if (nmf_in[1]) begin
               ctr_in  = nf_over_in;
               clen_in = nf_over_in ? DLW'(DATE_BYTES) : wtl_in;
               bsel_in = !bsel_in;
            end
         end
         ph_in = PH_HEAD; pmc_in = '0; nmf_in = 2'b11; nci_in = '0;
         tdc_in = '0; tdig_in = '0; acc_in = '0;
         nf_dig_in = 1'b0; nf_over_in = 1'b0; nf_stop_in = 1'b0;
         wlen_in = '0; wtl_in = '0;
      end

      if (in_eob) begin
         ent.sum_en         = 1'b1;
         ent.resp_code      = sc_in;
         ent.status_found   = sf_in;
         ent.body_length    = cl_in;
         ent.date_length    = clen_in;
         ent.date_truncated = ctr_in;
         ent.bank           = bsel_in;
         sc_in = '0; sf_in = 1'b0; cl_in = '0; bsel_in = 1'b0;
         clen_in = '0; ctr_in = 1'b0;
      end
   end

   assign q_push = accept && (ent.wr_en || ent.sum_en);
   assign q_data = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_HEAD; pmc_ff <= '0; nmf_ff <= 2'b11; nci_ff <= '0;
         tdc_ff <= '0; tdig_ff <= '0; acc_ff <= '0;
         nf_dig_ff <= 1'b0; nf_over_ff <= 1'b0; nf_stop_ff <= 1'b0;
         sc_ff <= '0; sf_ff <= 1'b0; cl_ff <= '0; bsel_ff <= 1'b0;
         wlen_ff <= '0; wtl_ff <= '0; clen_ff <= '0; ctr_ff <= 1'b0;
      end else if (accept) begin
         ph_ff <= ph_in; pmc_ff <= pmc_in; nmf_ff <= nmf_in; nci_ff <= nci_in;
         tdc_ff <= tdc_in; tdig_ff <= tdig_in; acc_ff <= acc_in;
         nf_dig_ff <= nf_dig_in; nf_over_ff <= nf_over_in; nf_stop_ff <= nf_stop_in;
         sc_ff <= sc_in; sf_ff <= sf_in; cl_ff <= cl_in; bsel_ff <= bsel_in;
         wlen_ff <= wlen_in; wtl_ff <= wtl_in; clen_ff <= clen_in; ctr_ff <= ctr_in;
      end
   end

endmodule

FILE: hw/rtl/hrs_queue.sv
// ----------------------------------------------------------------------------
// hrs_queue
// Short queue of write and summary commands between front and back.
// ----------------------------------------------------------------------------
module hrs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hrs_pkg::qent_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output hrs_pkg::qent_type head
);
   import hrs_pkg::*;

   qent_type       slot_ff [QDEPTH];
   logic [QPW-1:0] wp_ff, wp_in;
   logic [QPW-1:0] rp_ff, rp_in;
   logic [QPW:0]   cnt_ff, cnt_in;

   assign full      = (32'(cnt_ff) == QDEPTH);
   assign not_empty = (cnt_ff != '0);
   assign head      = slot_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + QPW'(1) : wp_ff;
      rp_in  = pop ? rp_ff + QPW'(1) : rp_ff;
      cnt_in = cnt_ff + (QPW+1)'(push) - (QPW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("queue read while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) <= QDEPTH) else $error("queue count out of range");

endmodule

FILE: hw/rtl/hrs_back.sv
// ----------------------------------------------------------------------------
// hrs_back
// Applies date writes to the two banks and emits summary and date results.
// ----------------------------------------------------------------------------
module hrs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  hrs_pkg::qent_type q_head,
   output logic              q_pop,
   hrs_rsp_if.source         rsp
);
   import hrs_pkg::*;

   logic [7:0]     mem [2*DATE_BYTES];
   logic [7:0]     rd_data_ff;

   back_state_type state_ff, state_in;
   logic [DLW-1:0] idx_ff, idx_in;
   logic [DLW-1:0] len_ff, len_in;
   logic           bank_ff, bank_in;
   logic           dok_ff, dok_in;

   logic           ov_ff, ov_in;
   logic           o_kind_ff, o_kind_in;
   logic [9:0]     o_sc_ff, o_sc_in;
   logic           o_sf_ff, o_sf_in;
   logic [LENGTH_BITS-1:0] o_cl_ff, o_cl_in;
   logic [DLW-1:0] o_dl_ff, o_dl_in;
   logic           o_dt_ff, o_dt_in;
   logic [7:0]     o_db_ff, o_db_in;
   logic           o_last_ff, o_last_in;

   logic           out_free;
   logic           load;

   assign out_free = !ov_ff || rsp.ready;

   always_comb begin
      state_in = state_ff; idx_in = idx_ff; len_in = len_ff; bank_in = bank_ff;
      dok_in = 1'b0;
      ov_in = ov_ff && !rsp.ready;
      o_kind_in = o_kind_ff; o_sc_in = o_sc_ff; o_sf_in = o_sf_ff; o_cl_in = o_cl_ff;
      o_dl_in = o_dl_ff; o_dt_in = o_dt_ff; o_db_in = o_db_ff; o_last_in = o_last_ff;
      q_pop = 1'b0;
      load  = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (q_not_empty && (!q_head.sum_en || out_free)) begin
               q_pop = 1'b1;
               if (q_head.sum_en) begin
                  load      = 1'b1;
                  ov_in     = 1'b1;
                  o_kind_in = KIND_SUMMARY;
                  o_sc_in   = q_head.resp_code;
                  o_sf_in   = q_head.status_found;
                  o_cl_in   = q_head.body_length;
                  o_dl_in   = q_head.date_length;
                  o_dt_in   = q_head.date_truncated;
                  o_db_in   = '0;
                  o_last_in = (q_head.date_length == '0);
                  idx_in    = '0;
                  len_in    = q_head.date_length;
                  bank_in   = q_head.bank;
                  if (q_head.date_length != '0) begin
                     state_in = BK_DRAIN;
                  end
               end
            end
         end
         BK_DRAIN: begin
            dok_in = 1'b1;
            if (dok_ff && out_free) begin
               load      = 1'b1;
               ov_in     = 1'b1;
               o_kind_in = KIND_DATE;
               o_sc_in   = '0;
               o_sf_in   = 1'b0;
               o_cl_in   = '0;
               o_dl_in   = '0;
               o_dt_in   = 1'b0;
               o_db_in   = rd_data_ff;
               o_last_in = (idx_ff + DLW'(1) == len_ff);
               idx_in    = idx_ff + DLW'(1);
               dok_in    = 1'b0;
               if (o_last_in) begin
                  state_in = BK_IDLE;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         dok_ff   <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         dok_ff   <= dok_in;
         ov_ff    <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in; len_ff <= len_in; bank_ff <= bank_in;
      o_kind_ff <= o_kind_in; o_sc_ff <= o_sc_in; o_sf_ff <= o_sf_in;
      o_cl_ff <= o_cl_in; o_dl_ff <= o_dl_in; o_dt_ff <= o_dt_in;
      o_db_ff <= o_db_in; o_last_ff <= o_last_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_head.wr_en) begin
         mem[q_head.wr_addr] <= q_head.wr_data;
      end
      rd_data_ff <= mem[{bank_ff, idx_ff[DAW-1:0]}];
   end

   assign rsp.valid          = ov_ff;
   assign rsp.kind           = o_kind_ff;
   assign rsp.resp_code      = o_sc_ff;
   assign rsp.status_found   = o_sf_ff;
   assign rsp.body_length    = o_cl_ff;
   assign rsp.date_length    = o_dl_ff;
   assign rsp.date_truncated = o_dt_ff;
   assign rsp.date_byte      = o_db_ff;
   assign rsp.last           = o_last_ff;

   a_no_pop_in_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_DRAIN |-> !q_pop) else $error("command taken during drain");
   a_drain_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_DRAIN |-> idx_ff < len_ff) else $error("drain index past length");
   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (load && o_last_in) |=> state_ff == BK_IDLE) else $error("drain not ended");
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> out_free) else $error("result overwritten");

endmodule

FILE: hw/rtl/http_response_header_scanner_core.sv
// ----------------------------------------------------------------------------
// http_response_header_scanner_core
// Scans response header bytes and reports status, length and date fields.
// ----------------------------------------------------------------------------
// The scanner takes one header byte per cycle as long as its command queue has
// room, also while an earlier block is still being drained. The request that
// ends a block yields one summary result and then the stored last-modified
// bytes, each fetched by a registered read of the date bank memory. A
// four-entry command queue sits between the byte scanner and the result
// stage, so the next block may begin while the previous one is still being
// drained, until that queue fills with date writes and summaries.
module http_response_header_scanner_core (
   input logic       clock,
   input logic       reset,
   hrs_req_if.sink   req,
   hrs_rsp_if.source rsp
);
   import hrs_pkg::*;

   qent_type q_in;
   qent_type q_head;
   logic     q_push;
   logic     q_pop;
   logic     q_full;
   logic     q_not_empty;

   hrs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_byte  (req.data_byte),
      .in_eob   (req.end_of_block),
      .in_ready (req.ready),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_in)
   );

   hrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   hrs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp         (rsp)
   );

endmodule
